>>> rtl/blk_pkg.sv
// ----------------------------------------------------------------------------
// BLAKE-256 package
// Shared types, constant tables and command structures of the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package blk_pkg;

	// Kind of block that the next compression works on.
	typedef enum logic [2:0] {
		KIND_FULL     = 3'd0,
		KIND_FIN_ONE  = 3'd1,
		KIND_FIN_TWOA = 3'd2,
		KIND_FIN_TWOB = 3'd3,
		KIND_FIN_FULA = 3'd4,
		KIND_FIN_FULB = 3'd5
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        byte_wr;
		logic        setup;
		kind_t       kind;
		logic        init_v;
		logic        g_half;
		logic        half;
		logic [2:0]  e_idx;
		logic [3:0]  sigma;
		logic        diag;
		logic        undiag;
		logic        finish;
		logic        clear;
		logic [2:0]  widx;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [6:0] fill;
	} status_t;

	localparam int unsigned BLK_BYTES = 64;
	localparam int unsigned PAD_LAST  = 55;
	localparam int unsigned LEN_OFF   = 56;
	localparam int unsigned NUM_ROUNDS = 14;
	localparam int unsigned NUM_SIGMA  = 10;

	localparam logic [3:0] SIGMA_TAB [0:9][0:15] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	localparam logic [31:0] PI_TAB [0:15] = '{
		32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
		32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89,
		32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
		32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917
	};

	localparam logic [31:0] IV_TAB [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

endpackage

`default_nettype wire

>>> rtl/blake256_hash_engine.sv
// ----------------------------------------------------------------------------
// BLAKE-256 hash engine
// Byte-wide message intake, 14-round compression and a word-wide digest.
// ----------------------------------------------------------------------------
// A byte that leaves its block unfinished is taken, and the engine stays ready for the next byte.
// Each compression does one G half-step a cycle in the datapath, with a diagonal and an undiagonal move each round.
// A final byte costs one or two compressions, then eight digest words, one a cycle while out_ready is high.
// No byte is taken during compression or while the digest drains.
// Reset loads the initial chain value and clears the counters; the buffer is left.
`default_nettype none

module blake256_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             digest_last
);
	import blk_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	blk_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.final_byte  (final_byte),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.word_index  (word_index),
		.digest_last (digest_last),
		.status      (status),
		.cmd         (cmd)
	);

	// Storage and arithmetic.
	blk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.status      (status),
		.digest_word (digest_word)
	);

endmodule

`default_nettype wire

>>> rtl/blk_dp.sv
// ----------------------------------------------------------------------------
// BLAKE-256 datapath
// Block buffer, chain value, counters and one half of the G function a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module blk_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire blk_pkg::cmd_t   cmd,
	input  wire logic [7:0]      data_byte,
	output blk_pkg::status_t     status,
	output logic [31:0]          digest_word
);
	import blk_pkg::*;

	logic [31:0] buf_q   [0:15];
	logic [31:0] chain_q [0:7];
	logic [31:0] v_q     [0:15];
	logic [63:0] bc_q;
	logic [63:0] tot_q;
	logic [6:0]  fill_q;
	logic [6:0]  blkf_q;
	logic        p80_q;
	logic        len_q;

	logic [3:0]  msg_addr;
	logic [3:0]  pi_addr;
	logic [31:0] msg_word;
	logic [31:0] v_g     [0:15];
	logic [31:0] v_rot   [0:15];
	logic [31:0] ga, gb, gc, gd;
	logic [63:0] fin_tot;
	logic [63:0] init_ctr;

	// Message word, with padding and length laid over the stored bytes.
	assign msg_addr = SIGMA_TAB[cmd.sigma][{cmd.e_idx, cmd.half}];
	assign pi_addr  = SIGMA_TAB[cmd.sigma][{cmd.e_idx, ~cmd.half}];

	always_comb begin
		logic [5:0] j;
		logic [7:0] b;
		msg_word = '0;
		for (int k = 0; k < 4; k++) begin
			j = {msg_addr, k[1:0]};
			b = 8'h00;
			if ({1'b0, j} < blkf_q) begin
				b = buf_q[msg_addr][8*(3-k) +: 8];
			end else begin
				if (({1'b0, j} == blkf_q) && p80_q)
					b = 8'h80;
				if (len_q && (j == 6'(PAD_LAST)))
					b = b | 8'h01;
				if (len_q && (j >= 6'(LEN_OFF)))
					b = tot_q[8*(7-int'(j[2:0])) +: 8];
			end
			msg_word[8*(3-k) +: 8] = b;
		end
	end

	// Half of G on column zero.
	always_comb begin
		logic [31:0] t;
		ga = v_q[0] + (msg_word ^ PI_TAB[pi_addr]) + v_q[4];
		t  = v_q[12] ^ ga;
		gd = cmd.half ? {t[7:0], t[31:8]} : {t[15:0], t[31:16]};
		gc = v_q[8] + gd;
		t  = v_q[4] ^ gc;
		gb = cmd.half ? {t[6:0], t[31:7]} : {t[11:0], t[31:12]};
		for (int i = 0; i < 16; i++)
			v_g[i] = v_q[i];
		v_g[0]  = ga;
		v_g[4]  = gb;
		v_g[8]  = gc;
		v_g[12] = gd;
		// Columns move left after the second half.
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				v_rot[4*r+c] = cmd.half ? v_g[4*r+((c+1)%4)] : v_g[4*r+c];
	end

	assign fin_tot = bc_q + {54'd0, fill_q, 3'd0};

	// A block of padding alone takes a zero counter.
	assign init_ctr = (blkf_q != 7'd0) ? tot_q : 64'd0;

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bc_q   <= '0;
			for (int i = 0; i < 8; i++)
				chain_q[i] <= IV_TAB[i];
		end else begin
			if (cmd.byte_wr)
				fill_q <= fill_q + 7'd1;
			if (cmd.setup && (cmd.kind == KIND_FULL)) begin
				fill_q <= '0;
				bc_q   <= bc_q + 64'd512;
			end
			if (cmd.finish)
				for (int i = 0; i < 8; i++)
					chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i+8];
			if (cmd.clear) begin
				fill_q <= '0;
				bc_q   <= '0;
				for (int i = 0; i < 8; i++)
					chain_q[i] <= IV_TAB[i];
			end
		end
	end

	// Payload registers: buffer, block description and work vector.
	always_ff @(posedge clk) begin
		if (cmd.byte_wr)
			buf_q[fill_q[5:2]][8*(3-int'(fill_q[1:0])) +: 8] <= data_byte;
		if (cmd.setup) begin
			unique case (cmd.kind)
				KIND_FULL: begin
					tot_q <= bc_q + 64'd512; blkf_q <= 7'd64; p80_q <= 1'b0; len_q <= 1'b0;
				end
				KIND_FIN_ONE: begin
					tot_q <= fin_tot; blkf_q <= fill_q; p80_q <= 1'b1; len_q <= 1'b1;
				end
				KIND_FIN_TWOA: begin
					tot_q <= fin_tot; blkf_q <= fill_q; p80_q <= 1'b1; len_q <= 1'b0;
				end
				KIND_FIN_TWOB: begin
					blkf_q <= 7'd0; p80_q <= 1'b0; len_q <= 1'b1;
				end
				KIND_FIN_FULA: begin
					tot_q <= fin_tot; blkf_q <= 7'd64; p80_q <= 1'b0; len_q <= 1'b0;
				end
				KIND_FIN_FULB: begin
					blkf_q <= 7'd0; p80_q <= 1'b1; len_q <= 1'b1;
				end
				default: begin
					blkf_q <= 7'd0; p80_q <= 1'b0; len_q <= 1'b0;
				end
			endcase
		end
		if (cmd.init_v) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= chain_q[i];
			for (int i = 0; i < 4; i++)
				v_q[i+8] <= PI_TAB[i];
			v_q[12] <= PI_TAB[4] ^ init_ctr[31:0];
			v_q[13] <= PI_TAB[5] ^ init_ctr[31:0];
			v_q[14] <= PI_TAB[6] ^ init_ctr[63:32];
			v_q[15] <= PI_TAB[7] ^ init_ctr[63:32];
		end
		if (cmd.g_half)
			for (int i = 0; i < 16; i++)
				v_q[i] <= v_rot[i];
		if (cmd.diag)
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					v_q[4*r+c] <= v_q[4*r+((c+r)%4)];
		if (cmd.undiag)
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					v_q[4*r+c] <= v_q[4*r+((c+4-r)%4)];
	end

	assign status.fill  = fill_q;
	assign digest_word  = chain_q[cmd.widx];

endmodule

`default_nettype wire

>>> rtl/blk_ctrl.sv
// ----------------------------------------------------------------------------
// BLAKE-256 controller
// Sequences byte intake, padding blocks, the fourteen rounds and the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module blk_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              final_byte,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             word_index,
	output logic                   digest_last,
	input  wire blk_pkg::status_t  status,
	output blk_pkg::cmd_t          cmd
);
	import blk_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SETUP  = 8'b0000_0010,
		ST_INIT   = 8'b0000_0100,
		ST_GH     = 8'b0000_1000,
		ST_DIAG   = 8'b0001_0000,
		ST_UNDIAG = 8'b0010_0000,
		ST_FIN    = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t      state_q;
	kind_t       kind_q;
	logic        pend_q;
	logic        final_q;
	logic        half_q;
	logic [1:0]  g_q;
	logic        diag_q;
	logic [3:0]  round_q;
	logic [3:0]  sigma_q;
	logic [2:0]  widx_q;
	logic [6:0]  new_fill;

	assign new_fill = status.fill + 7'd1;

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_FULL;
			pend_q  <= 1'b0;
			final_q <= 1'b0;
			half_q  <= 1'b0;
			g_q     <= '0;
			diag_q  <= 1'b0;
			round_q <= '0;
			sigma_q <= '0;
			widx_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						final_q <= final_byte;
						pend_q  <= 1'b0;
						if (final_byte) begin
							state_q <= ST_SETUP;
							if (new_fill == 7'(BLK_BYTES)) begin
								kind_q <= KIND_FIN_FULA;
								pend_q <= 1'b1;
							end else if (new_fill > 7'(PAD_LAST)) begin
								kind_q <= KIND_FIN_TWOA;
								pend_q <= 1'b1;
							end else begin
								kind_q <= KIND_FIN_ONE;
							end
						end else if (new_fill == 7'(BLK_BYTES)) begin
							kind_q  <= KIND_FULL;
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: state_q <= ST_INIT;
				ST_INIT: begin
					half_q  <= 1'b0;
					g_q     <= '0;
					diag_q  <= 1'b0;
					round_q <= '0;
					sigma_q <= '0;
					state_q <= ST_GH;
				end
				ST_GH: begin
					half_q <= ~half_q;
					if (half_q) begin
						g_q <= g_q + 2'd1;
						if (g_q == 2'd3)
							state_q <= diag_q ? ST_UNDIAG : ST_DIAG;
					end
				end
				ST_DIAG: begin
					diag_q  <= 1'b1;
					state_q <= ST_GH;
				end
				ST_UNDIAG: begin
					diag_q  <= 1'b0;
					round_q <= round_q + 4'd1;
					sigma_q <= (sigma_q == 4'(NUM_SIGMA - 1)) ? 4'd0 : sigma_q + 4'd1;
					state_q <= (round_q == 4'(NUM_ROUNDS - 1)) ? ST_FIN : ST_GH;
				end
				ST_FIN: begin
					if (pend_q) begin
						pend_q  <= 1'b0;
						kind_q  <= (kind_q == KIND_FIN_FULA) ? KIND_FIN_FULB : KIND_FIN_TWOB;
						state_q <= ST_SETUP;
					end else if (final_q) begin
						widx_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd         = '0;
		cmd.kind    = kind_q;
		cmd.half    = half_q;
		cmd.e_idx   = {diag_q, g_q};
		cmd.sigma   = sigma_q;
		cmd.widx    = widx_q;
		cmd.byte_wr = (state_q == ST_IDLE) && in_valid;
		cmd.setup   = (state_q == ST_SETUP);
		cmd.init_v  = (state_q == ST_INIT);
		cmd.g_half  = (state_q == ST_GH);
		cmd.diag    = (state_q == ST_DIAG);
		cmd.undiag  = (state_q == ST_UNDIAG);
		cmd.finish  = (state_q == ST_FIN);
		cmd.clear   = (state_q == ST_OUT) && out_ready && (widx_q == 3'd7);
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign word_index  = widx_q;
	assign digest_last = (widx_q == 3'd7);

endmodule

`default_nettype wire
